FILE: rtl/ral_pkg.sv
`default_nettype none
package ral_pkg;

    localparam int SLOT_W            = 11;
    localparam int POOL_SLOTS_DEF    = 1024;
    localparam int FREE_ENTRIES_DEF  = 16;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD       = 3'd3,
        ST_LIST_FULL = 3'd4
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] count;
        logic [SLOT_W-1:0] range_start;
        logic [SLOT_W-1:0] range_end;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] given_start;
        logic [SLOT_W-1:0] given_end;
        logic [SLOT_W-1:0] used_top;
    } rsp_t;

    typedef struct packed {
        logic [SLOT_W-1:0] first;
        logic [SLOT_W-1:0] last;
    } ent_t;

endpackage
`default_nettype wire

FILE: rtl/ral_free_mem.sv
`default_nettype none
module ral_free_mem
    import ral_pkg::*;
#(
    parameter int DEPTH = FREE_ENTRIES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire ent_t          wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output ent_t               rd_data
);

    ent_t mem [DEPTH];
    ent_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: rtl/range_allocator_coalescing_free_list_core.sv
// First-fit range allocator over a pool of 1-based slots, with a coalescing
// free list held in a small synchronous RAM.
// Request channel: req_valid / req_stall / req. A beat carries op
// (allocate or free), count, range_start and range_end. A new beat is taken
// only while the sequencer is idle; one request is in work at a time.
// Response channel: rsp_valid / rsp_stall / rsp. Each request gives one beat
// with status, the allocated range and the top of the used region.
// A rejected request goes straight to the final state. An allocate walks
// the list entry by entry, a read and then a check, until a fit or the end
// of the list; an exact fit removes its entry by moving each later entry
// down. A free runs compaction passes over the list: each pass reads entry
// pairs through the single RAM read port.
// The response sits in an output register; the next request is taken while
// a stalled response waits, and the sequencer holds in its final state only
// if a second response is ready before the first is taken.
// Reset clears the list fill count, the top of the used region and the
// response valid; RAM contents are not cleared.
`default_nettype none
module range_allocator_coalescing_free_list_core
    import ral_pkg::*;
#(
    parameter int POOL_SLOTS   = POOL_SLOTS_DEF,
    parameter int FREE_ENTRIES = FREE_ENTRIES_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int TW0 = $clog2(POOL_SLOTS + 1);
    localparam int TW  = (TW0 > SLOT_W) ? TW0 : SLOT_W;
    localparam int AW  = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int CW  = $clog2(FREE_ENTRIES + 1);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_SRCH_RD  = 10'b0000000010,
        S_SRCH_CHK = 10'b0000000100,
        S_CMP_A_RD = 10'b0000001000,
        S_CMP_A_CK = 10'b0000010000,
        S_CMP_B_RD = 10'b0000100000,
        S_CMP_B_CK = 10'b0001000000,
        S_DROP_RD  = 10'b0010000000,
        S_DROP_WR  = 10'b0100000000,
        S_FIN      = 10'b1000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [TW-1:0]     top_reg, top_next;
    logic [CW-1:0]     a_reg, a_next;
    logic [CW-1:0]     b_reg, b_next;
    logic [CW-1:0]     m_reg, m_next;
    logic              ret_cmp_reg, ret_cmp_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    ent_t              ea_reg, ea_next;
    status_t           st_reg, st_next;
    logic [SLOT_W-1:0] gs_reg, gs_next;
    logic [SLOT_W-1:0] ge_reg, ge_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    ent_t              wr_data;
    logic [AW-1:0]     rd_addr;
    ent_t              rd_data;

    logic [SLOT_W:0]   len;
    logic [SLOT_W:0]   alloc_last;
    logic [TW:0]       grow;
    logic [CW-1:0]     m_inc;
    logic              adj;

    ral_free_mem #(
        .DEPTH (FREE_ENTRIES)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign len        = {1'b0, rd_data.last} - {1'b0, rd_data.first} + (SLOT_W+1)'(1);
    assign alloc_last = {1'b0, rd_data.first} + {1'b0, cnt_reg} - (SLOT_W+1)'(1);
    assign grow       = {1'b0, top_reg} + (TW+1)'(cnt_reg);
    assign m_inc      = m_reg + CW'(1);
    assign adj        = ({1'b0, ea_reg.last} + (SLOT_W+1)'(1) == {1'b0, rd_data.first})
                     || ({1'b0, rd_data.last} + (SLOT_W+1)'(1) == {1'b0, ea_reg.first});

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        top_next       = top_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        m_next         = m_reg;
        ret_cmp_next   = ret_cmp_reg;
        cnt_next       = cnt_reg;
        ea_next        = ea_reg;
        st_next        = st_reg;
        gs_next        = gs_reg;
        ge_next        = ge_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        wr_addr        = fill_reg[AW-1:0];
        wr_data        = '{first: req.range_start, last: req.range_end};
        rd_addr        = a_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cnt_next = req.count;
                    st_next  = ST_OK;
                    gs_next  = '0;
                    ge_next  = '0;
                    a_next   = '0;
                    if (req.op == OP_ALLOC)
                    begin
                        if (req.count == '0)
                        begin
                            st_next    = ST_ZERO;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            a_next     = '0;
                            state_next = S_SRCH_RD;
                        end
                    end
                    else if (req.range_start == '0 || req.range_start > req.range_end
                             || TW'(req.range_end) > top_reg)
                    begin
                        st_next    = ST_BAD;
                        state_next = S_FIN;
                    end
                    else if (fill_reg >= CW'(FREE_ENTRIES))
                    begin
                        st_next    = ST_LIST_FULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        fill_next  = fill_reg + CW'(1);
                        state_next = S_CMP_A_RD;
                    end
                end
            end

            S_SRCH_RD:
            begin
                rd_addr = a_reg[AW-1:0];
                if (a_reg >= fill_reg)
                begin
                    if (grow > (TW+1)'(POOL_SLOTS))
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        gs_next  = SLOT_W'(top_reg + TW'(1));
                        ge_next  = SLOT_W'(grow);
                        top_next = TW'(grow);
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SRCH_CHK;
                end
            end

            S_SRCH_CHK:
            begin
                if ({1'b0, cnt_reg} <= len)
                begin
                    if (rd_data.first != '0 && (TW+1)'(alloc_last) <= {1'b0, top_reg})
                    begin
                        gs_next = rd_data.first;
                        ge_next = alloc_last[SLOT_W-1:0];
                    end
                    else
                    begin
                        st_next = ST_BAD;
                    end
                    if ({1'b0, cnt_reg} < len)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = a_reg[AW-1:0];
                        wr_data    = '{first: rd_data.first + cnt_reg, last: rd_data.last};
                        state_next = S_FIN;
                    end
                    else
                    begin
                        m_next       = a_reg;
                        ret_cmp_next = 1'b0;
                        state_next   = S_DROP_RD;
                    end
                end
                else
                begin
                    a_next     = a_reg + CW'(1);
                    state_next = S_SRCH_RD;
                end
            end

            S_CMP_A_RD:
            begin
                rd_addr = a_reg[AW-1:0];
                if (a_reg >= fill_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_CMP_A_CK;
                end
            end

            S_CMP_A_CK:
            begin
                ea_next = rd_data;
                if (TW'(rd_data.last) == top_reg)
                begin
                    top_next     = TW'(rd_data.first) - TW'(1);
                    m_next       = a_reg;
                    ret_cmp_next = 1'b1;
                    state_next   = S_DROP_RD;
                end
                else
                begin
                    b_next     = a_reg + CW'(1);
                    state_next = S_CMP_B_RD;
                end
            end

            S_CMP_B_RD:
            begin
                rd_addr = b_reg[AW-1:0];
                if (b_reg >= fill_reg)
                begin
                    a_next     = a_reg + CW'(1);
                    state_next = S_CMP_A_RD;
                end
                else
                begin
                    state_next = S_CMP_B_CK;
                end
            end

            S_CMP_B_CK:
            begin
                if (adj)
                begin
                    wr_en        = 1'b1;
                    wr_addr      = a_reg[AW-1:0];
                    wr_data.first = (rd_data.first < ea_reg.first) ? rd_data.first
                                                                   : ea_reg.first;
                    wr_data.last  = (rd_data.last > ea_reg.last) ? rd_data.last
                                                                 : ea_reg.last;
                    m_next       = b_reg;
                    ret_cmp_next = 1'b1;
                    state_next   = S_DROP_RD;
                end
                else
                begin
                    b_next     = b_reg + CW'(1);
                    state_next = S_CMP_B_RD;
                end
            end

            S_DROP_RD:
            begin
                rd_addr = m_inc[AW-1:0];
                if (m_inc >= fill_reg)
                begin
                    fill_next = fill_reg - CW'(1);
                    a_next    = '0;
                    if (ret_cmp_reg)
                    begin
                        state_next = S_CMP_A_RD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_DROP_WR;
                end
            end

            S_DROP_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = m_reg[AW-1:0];
                wr_data    = rd_data;
                m_next     = m_inc;
                state_next = S_DROP_RD;
            end

            S_FIN:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next.status      = st_reg;
                    out_next.given_start = gs_reg;
                    out_next.given_end   = ge_reg;
                    out_next.used_top    = top_reg[SLOT_W-1:0];
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        m_reg       <= m_next;
        ret_cmp_reg <= ret_cmp_next;
        cnt_reg     <= cnt_next;
        ea_reg      <= ea_next;
        st_reg      <= st_next;
        gs_reg      <= gs_next;
        ge_reg      <= ge_next;
        out_reg     <= out_next;
    end

endmodule
`default_nettype wire
